[hdl/concurrency_window_feedback_unit_macros.svh]
// Assertion macros shared by the checker of the concurrency window unit.
// No dependencies.
`ifndef CONCURRENCY_WINDOW_FEEDBACK_UNIT_MACROS_SVH
`define CONCURRENCY_WINDOW_FEEDBACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWF_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("concurrency window check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("concurrency window check failed");

`endif

[hdl/cwf_pkg.sv]
// Package of the concurrency window unit: payload structs, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cwf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WINDOW_MAX = 1023;
    localparam int WIN_W      = 10;
    localparam int CFG_W      = 10;
    localparam int DSU_W      = 34;
    localparam int DSU_CNT_W  = 6;

    localparam logic [1:0]       RST_METHOD = 2'd1;
    localparam logic [7:0]       RST_HYST   = 8'd1;
    localparam logic [7:0]       RST_DEAD   = 8'd1;
    localparam logic [WIN_W-1:0] RST_INIT   = 10'd5;
    localparam logic [WIN_W-1:0] RST_LIMIT  = 10'd20;

    typedef enum logic [1:0] {
        METH_FIXED = 2'd0,
        METH_INV   = 2'd1,
        METH_ISQRT = 2'd2,
        METH_ALT   = 2'd3
    } t_method;

    typedef enum logic [2:0] {
        CFG_POS_METHOD = 3'd0,
        CFG_NEG_METHOD = 3'd1,
        CFG_POS_HYST   = 3'd2,
        CFG_NEG_HYST   = 3'd3,
        CFG_DEAD       = 3'd4,
        CFG_INIT_WIN   = 3'd5,
        CFG_WIN_LIMIT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [0:0] {
        DSU_DIV  = 1'b0,
        DSU_SQRT = 1'b1
    } t_dsu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIV,
        ST_SQRT,
        ST_ACC,
        ST_GROW,
        ST_FAIL,
        ST_OUT
    } t_cwf_state;

    typedef struct packed {
        logic                 mode;
        logic [WIN_W-1:0]     busy_count;
    } t_cwf_in;

    typedef struct packed {
        logic [WIN_W-1:0]     window_now;
        logic                 start_backoff;
        logic                 revived;
        logic                 status;
    } t_cwf_out;

    typedef struct packed {
        logic                 start;
        t_dsu_op              op;
        logic [DSU_W-1:0]     operand;
        logic [WIN_W-1:0]     divisor;
        logic [DSU_CNT_W-1:0] steps;
    } t_dsu_req;

    typedef struct packed {
        logic                 done;
        logic [DSU_W-1:0]     quot;
        logic [WIN_W-1:0]     rem;
    } t_dsu_rsp;

endpackage
`default_nettype wire

[hdl/cwf_divsqrt.sv]
// Shared restoring divide and digit-by-digit square root unit, one step per cycle.
// Depends on cwf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cwf_divsqrt (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cwf_pkg::t_dsu_req i_req,
    output cwf_pkg::t_dsu_rsp     o_rsp
);
    import cwf_pkg::*;

    localparam int ACC_W = 21;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    t_dsu_op              r_op, n_op;
    logic [DSU_CNT_W-1:0] r_cnt, n_cnt;
    logic [DSU_W-1:0]     r_src, n_src;
    logic [DSU_W-1:0]     r_q, n_q;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [WIN_W-1:0]     r_div, n_div;

    logic [ACC_W-1:0]     cand;
    logic [ACC_W-1:0]     subtr;
    logic [ACC_W:0]       diff;
    logic                 ge;

    // The one subtractor, shared by both operations.
    always_comb begin
        if (r_op == DSU_DIV) begin
            cand  = {10'd0, r_acc[WIN_W-1:0], r_src[DSU_W-1]};
            subtr = {11'd0, r_div};
        end else begin
            cand  = {r_acc[18:0], r_src[DSU_W-1 -: 2]};
            subtr = {2'd0, r_q[16:0], 2'b01};
        end
        diff = {1'b0, cand} - {1'b0, subtr};
        ge   = !diff[ACC_W];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_src  = r_src;
        n_q    = r_q;
        n_acc  = r_acc;
        n_div  = r_div;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = i_req.steps;
            n_src  = i_req.operand;
            n_q    = '0;
            n_acc  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_acc = ge ? diff[ACC_W-1:0] : cand;
            n_q   = {r_q[DSU_W-2:0], ge};
            n_src = (r_op == DSU_DIV) ? {r_src[DSU_W-2:0], 1'b0} : {r_src[DSU_W-3:0], 2'b00};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DSU_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= DSU_DIV;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_src <= n_src;
        r_q   <= n_q;
        r_acc <= n_acc;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_acc[WIN_W-1:0];

endmodule
`default_nettype wire

[hdl/concurrency_window_feedback_unit.sv]
// Top level of the concurrency window unit: sequencer, state and configuration.
// Depends on cwf_pkg and cwf_divsqrt.
//
// This block keeps the concurrency window of one destination and adjusts it
// for each delivery outcome request. It works on one request at a time: while
// a request is in flight o_in_stall stays high, and the result is held on the
// output until it is taken. No feedback is computed on a revival, a failure
// while dead or a success with the window already at its bound. A failure
// divides 2^32/w and then takes a square root when 1/sqrt(w) is needed. A
// success with feedback also splits the success accumulator by the growth
// step, after the division and square root that 1/w and 1/sqrt(w) need. The
// output then waits on i_out_stall. The shared divide and square root unit
// retires one quotient bit or one root bit per cycle: 33 steps for 2^32/w,
// 17 steps for the square root, 9 steps for the growth split. Feedback values
// are unsigned with 16 fraction bits and always truncated; 1/w is taken as
// the upper half of 2^32/w, so one division serves both the failure cohort
// count and the inverse square root. Configuration is written through
// i_cfg_we, i_cfg_idx and i_cfg_data and must only be written while the
// block is idle; writing initial_window never moves the window.
`timescale 1ns / 1ps
`default_nettype none
module concurrency_window_feedback_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire cwf_pkg::t_cwf_in              i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output cwf_pkg::t_cwf_out                  o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_idx,
    input  wire logic [cwf_pkg::CFG_W-1:0]     i_cfg_data
);
    import cwf_pkg::*;

    localparam logic [16:0] FB_ONE = 17'h10000;

    // Configuration registers.
    logic [1:0]       r_pos_method;
    logic [1:0]       r_neg_method;
    logic [7:0]       r_pos_hyst;
    logic [7:0]       r_neg_hyst;
    logic [7:0]       r_dead;
    logic [WIN_W-1:0] r_init;
    logic [WIN_W-1:0] r_limit;

    // Destination state and the request being worked on.
    t_cwf_state       r_state, n_state;
    logic [WIN_W-1:0] r_window, n_window;
    logic [24:0]      r_succ, n_succ;
    logic [25:0]      r_fail, n_fail;
    logic [24:0]      r_coh, n_coh;
    t_cwf_in          r_req, n_req;
    logic [16:0]      r_fb, n_fb;
    t_cwf_out         r_out, n_out;

    t_dsu_req         dsu_req;
    t_dsu_rsp         dsu_rsp;

    logic [7:0]       pos_h;
    logic [7:0]       neg_h;
    logic             grow_ok;
    logic [16:0]      q_inv;
    logic [24:0]      acc_sum;
    logic [24:0]      coh_sum;
    logic             dead_hit;
    logic [8:0]       acc_hi;
    logic [8:0]       growth;
    logic [10:0]      grown;
    logic [WIN_W-1:0] grown_sat;
    logic [WIN_W-1:0] revive_w;
    logic             fb_over;
    logic             pos_isqrt;
    logic             neg_isqrt;

    // A hysteresis of zero acts as one.
    assign pos_h = (r_pos_hyst == 8'd0) ? 8'd1 : r_pos_hyst;
    assign neg_h = (r_neg_hyst == 8'd0) ? 8'd1 : r_neg_hyst;

    // Growth is only allowed below the limit, if one is set, and below busy + initial window.
    assign grow_ok = ((r_limit == '0) || (r_limit > r_window))
                     && ({1'b0, r_window} < ({1'b0, r_req.busy_count} + {1'b0, r_init}));

    // The upper half of 2^32/w is 2^16/w, the inverse window feedback.
    assign q_inv    = dsu_rsp.quot[32:16];
    assign acc_sum  = r_succ + {8'd0, r_fb};
    assign coh_sum  = r_coh + {8'd0, q_inv};
    assign dead_hit = (coh_sum >= {1'b0, r_dead, 16'd0});

    // After the split, accumulated_steps * pos_h is the integer part minus the
    // remainder, so the window grows without a multiplier.
    assign acc_hi    = r_succ[24:16];
    assign growth    = acc_hi - {1'b0, dsu_rsp.rem[7:0]};
    assign grown     = {1'b0, r_window} + {2'b0, growth};
    assign grown_sat = (grown > 11'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX) : grown[WIN_W-1:0];

    // Revival takes the busy count, else the initial window, never zero.
    always_comb begin
        revive_w = (r_req.busy_count != '0) ? r_req.busy_count : r_init;
        if (revive_w == '0) begin
            revive_w = WIN_W'(1);
        end
    end

    assign fb_over   = ({9'd0, r_fb} > r_fail);
    // Method code three behaves as the inverse square root.
    assign pos_isqrt = (r_pos_method == METH_ISQRT) || (r_pos_method == METH_ALT);
    assign neg_isqrt = (r_neg_method == METH_ISQRT) || (r_neg_method == METH_ALT);

    cwf_divsqrt u_dsu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dsu_req),
        .o_rsp   (dsu_rsp)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (r_req.mode == 1'b0) begin
                    if (r_window == '0 || !grow_ok) begin
                        n_state = ST_OUT;
                    end else if (r_pos_method == METH_FIXED) begin
                        n_state = ST_ACC;
                    end else begin
                        n_state = ST_DIV;
                    end
                end else if (r_window == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (dsu_rsp.done) begin
                    if (r_req.mode == 1'b0) begin
                        n_state = pos_isqrt ? ST_SQRT : ST_ACC;
                    end else if (dead_hit) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = neg_isqrt ? ST_SQRT : ST_FAIL;
                    end
                end
            end
            ST_SQRT: begin
                if (dsu_rsp.done) begin
                    n_state = (r_req.mode == 1'b0) ? ST_ACC : ST_FAIL;
                end
            end
            ST_ACC: begin
                n_state = ST_GROW;
            end
            ST_GROW: begin
                if (dsu_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_FAIL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and requests to the shared unit, per state.
    always_comb begin
        n_window = r_window;
        n_succ   = r_succ;
        n_fail   = r_fail;
        n_coh    = r_coh;
        n_req    = r_req;
        n_fb     = r_fb;
        n_out    = r_out;
        dsu_req  = '{start: 1'b0, op: DSU_DIV, operand: '0, divisor: r_window, steps: '0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                end
            end
            ST_CLASSIFY: begin
                n_out = '{window_now: r_window, start_backoff: 1'b0, revived: 1'b0,
                          status: 1'b0};
                if (r_req.mode == 1'b0) begin
                    // Every success clears the failure cohort count.
                    n_coh = '0;
                    if (r_window == '0) begin
                        n_window          = revive_w;
                        n_succ            = '0;
                        n_fail            = '0;
                        n_out.window_now  = revive_w;
                        n_out.revived     = 1'b1;
                    end else if (grow_ok) begin
                        if (r_pos_method == METH_FIXED) begin
                            n_fb = FB_ONE;
                        end else begin
                            dsu_req = '{start: 1'b1, op: DSU_DIV,
                                        operand: {1'b1, 33'd0}, divisor: r_window,
                                        steps: DSU_CNT_W'(33)};
                        end
                    end
                end else if (r_window == '0) begin
                    // A failure while dead is reported and ignored.
                    n_out.status = 1'b1;
                end else begin
                    dsu_req = '{start: 1'b1, op: DSU_DIV, operand: {1'b1, 33'd0},
                                divisor: r_window, steps: DSU_CNT_W'(33)};
                end
            end
            ST_DIV: begin
                if (dsu_rsp.done) begin
                    n_fb = q_inv;
                    if (r_req.mode == 1'b1) begin
                        n_coh = coh_sum;
                        if (dead_hit) begin
                            n_window                = '0;
                            n_out.window_now        = '0;
                            n_out.start_backoff     = 1'b1;
                        end else if (r_neg_method == METH_FIXED) begin
                            n_fb = FB_ONE;
                        end
                    end
                    if ((r_req.mode == 1'b0 && pos_isqrt)
                        || (r_req.mode == 1'b1 && !dead_hit && neg_isqrt)) begin
                        dsu_req = '{start: 1'b1, op: DSU_SQRT,
                                    operand: {1'b0, dsu_rsp.quot[32:0]},
                                    divisor: r_window, steps: DSU_CNT_W'(17)};
                    end
                end
            end
            ST_SQRT: begin
                if (dsu_rsp.done) begin
                    n_fb = dsu_rsp.quot[16:0];
                end
            end
            ST_ACC: begin
                // Add the feedback, then split the sum by the growth step.
                n_succ  = acc_sum;
                dsu_req = '{start: 1'b1, op: DSU_DIV, operand: {acc_sum[24:16], 25'd0},
                            divisor: {2'd0, pos_h}, steps: DSU_CNT_W'(9)};
            end
            ST_GROW: begin
                if (dsu_rsp.done) begin
                    if (growth != '0) begin
                        n_succ   = {dsu_rsp.rem[8:0], r_succ[15:0]};
                        n_fail   = '0;
                        n_window = grown_sat;
                    end
                    if (r_limit != '0 && n_window > r_limit) begin
                        n_window = r_limit;
                    end
                    n_out.window_now = n_window;
                end
            end
            ST_FAIL: begin
                if (fb_over) begin
                    // The failure accumulator ran short: refill and shrink.
                    n_fail   = r_fail + {2'd0, neg_h, 16'd0} - {9'd0, r_fb};
                    n_succ   = '0;
                    n_window = (r_window > {2'd0, neg_h}) ? (r_window - {2'd0, neg_h})
                                                          : WIN_W'(1);
                end else begin
                    n_fail = r_fail - {9'd0, r_fb};
                end
                n_out.window_now = n_window;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_window     <= RST_INIT;
            r_succ       <= '0;
            r_fail       <= '0;
            r_coh        <= '0;
            r_pos_method <= RST_METHOD;
            r_neg_method <= RST_METHOD;
            r_pos_hyst   <= RST_HYST;
            r_neg_hyst   <= RST_HYST;
            r_dead       <= RST_DEAD;
            r_init       <= RST_INIT;
            r_limit      <= RST_LIMIT;
        end else begin
            r_state  <= n_state;
            r_window <= n_window;
            r_succ   <= n_succ;
            r_fail   <= n_fail;
            r_coh    <= n_coh;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_POS_METHOD: r_pos_method <= i_cfg_data[1:0];
                    CFG_NEG_METHOD: r_neg_method <= i_cfg_data[1:0];
                    CFG_POS_HYST:   r_pos_hyst   <= i_cfg_data[7:0];
                    CFG_NEG_HYST:   r_neg_hyst   <= i_cfg_data[7:0];
                    CFG_DEAD:       r_dead       <= i_cfg_data[7:0];
                    CFG_INIT_WIN:   r_init       <= i_cfg_data;
                    CFG_WIN_LIMIT:  r_limit      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_req <= n_req;
        r_fb  <= n_fb;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

[hdl/cwf_checker.sv]
// Port-level checks of the concurrency window unit, bound to its top level.
// Depends on cwf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "concurrency_window_feedback_unit_macros.svh"
module cwf_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire cwf_pkg::t_cwf_out         o_out_data
);
    import cwf_pkg::*;

    `CWF_ASSERT_IMPL(a_one_at_a_time, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `CWF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall && !o_out_valid)
    `CWF_ASSERT_IMPL(a_status_dead, i_clk, i_rst_n, o_out_valid && o_out_data.status, o_out_data.window_now == '0 && !o_out_data.start_backoff && !o_out_data.revived)
    `CWF_ASSERT_IMPL(a_flags_window, i_clk, i_rst_n, o_out_valid, (o_out_data.start_backoff == (o_out_data.window_now == '0 && !o_out_data.status)) && !(o_out_data.revived && o_out_data.window_now == '0))
    `CWF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind concurrency_window_feedback_unit cwf_checker u_cwf_checker (.*);
`default_nettype wire
